// ----- hw/rtl/assert_macros.svh -----
// Assertion macros included by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- hw/rtl/rcvp_pkg.sv -----
// Package: constants, types and the serial type classifier for the record parser
package rcvp_pkg;
	localparam int MaxColumns = 32;
	localparam int ColW = $clog2(MaxColumns);
	localparam int CntW = $clog2(MaxColumns + 1);

	localparam logic [1:0] KIND_COL  = 2'd0;
	localparam logic [1:0] KIND_TEXT = 2'd1;
	localparam logic [1:0] KIND_FIN  = 2'd2;

	localparam logic [2:0] CLS_NULL = 3'd0;
	localparam logic [2:0] CLS_INT  = 3'd1;
	localparam logic [2:0] CLS_FLT  = 3'd2;
	localparam logic [2:0] CLS_ZERO = 3'd3;
	localparam logic [2:0] CLS_ONE  = 3'd4;
	localparam logic [2:0] CLS_RSV  = 3'd5;
	localparam logic [2:0] CLS_BLOB = 3'd6;
	localparam logic [2:0] CLS_TEXT = 3'd7;

	typedef struct packed {
		logic [7:0] cell_byte;
		logic       cell_first;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  item_kind;
		logic [4:0]  column_index;
		logic [2:0]  type_class;
		logic [15:0] data_size;
		logic [63:0] raw_value;
		logic [7:0]  text_value_byte;
		logic [63:0] row_identifier;
		logic        truncated;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  cls;
		logic [15:0] size;
	} col_info_t;

	function automatic col_info_t classify(input logic [31:0] st);
		col_info_t r;
		logic [30:0] s;
		s = 31'(st >> 1) - 31'd6;
		r.size = 16'd0;
		if (st == 32'd0) r.cls = CLS_NULL;
		else if (st <= 32'd6) begin
			r.cls = CLS_INT;
			case (st[2:0])
				3'd5: r.size = 16'd6;
				3'd6: r.size = 16'd8;
				default: r.size = {13'd0, st[2:0]};
			endcase
		end else if (st == 32'd7) begin
			r.cls = CLS_FLT;
			r.size = 16'd8;
		end else if (st == 32'd8) r.cls = CLS_ZERO;
		else if (st == 32'd9) r.cls = CLS_ONE;
		else if (st < 32'd12) r.cls = CLS_RSV;
		else begin
			r.cls = st[0] ? CLS_TEXT : CLS_BLOB;
			r.size = (s > 31'h0000FFFF) ? 16'hFFFF : s[15:0];
		end
		return r;
	endfunction
endpackage

// ----- hw/rtl/rcvp_if.sv -----
// Valid/ready channel interfaces for input and result items
interface rcvp_in_if;
	logic valid;
	logic ready;
	logic [7:0] cell_byte;
	logic cell_first;
	modport source (output valid, cell_byte, cell_first, input ready);
	modport sink (input valid, cell_byte, cell_first, output ready);
endinterface

interface rcvp_out_if;
	logic valid;
	logic ready;
	logic [1:0] item_kind;
	logic [4:0] column_index;
	logic [2:0] type_class;
	logic [15:0] data_size;
	logic [63:0] raw_value;
	logic [7:0] text_value_byte;
	logic [63:0] row_identifier;
	logic truncated;
	logic last;
	modport source (output valid, item_kind, column_index, type_class, data_size,
		raw_value, text_value_byte, row_identifier, truncated, last, input ready);
	modport sink (input valid, item_kind, column_index, type_class, data_size,
		raw_value, text_value_byte, row_identifier, truncated, last, output ready);
endinterface

// ----- hw/rtl/rcvp_store.sv -----
// Serial type memory: one write port, one registered read port
module rcvp_store (
	input  logic                     clk,
	input  logic                     we,
	input  logic [rcvp_pkg::ColW-1:0] waddr,
	input  logic [31:0]              wdata,
	input  logic [rcvp_pkg::ColW-1:0] raddr,
	output logic [31:0]              rdata
);
	logic [31:0] mem [rcvp_pkg::MaxColumns];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// ----- hw/rtl/rcvp_ctrl.sv -----
// Parse sequencer: varint decode, header capture and data-area walk
module rcvp_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  rcvp_pkg::in_item_t       in_item,
	output logic                     res_valid,
	input  logic                     res_ready,
	output rcvp_pkg::out_item_t      res_item,
	output logic                     st_we,
	output logic [rcvp_pkg::ColW-1:0] st_waddr,
	output logic [31:0]              st_wdata,
	output logic [rcvp_pkg::ColW-1:0] st_raddr,
	input  logic [31:0]              st_rdata
);
	localparam logic [3:0] PH_IDLE = 4'd0;
	localparam logic [3:0] PH_PAY  = 4'd1;
	localparam logic [3:0] PH_ROW  = 4'd2;
	localparam logic [3:0] PH_HDR  = 4'd3;
	localparam logic [3:0] PH_SER  = 4'd4;
	localparam logic [3:0] PH_DATA = 4'd5;
	localparam logic [3:0] PH_DONE = 4'd6;
	localparam logic [3:0] PH_ENT  = 4'd7; // memory read issued for current column
	localparam logic [3:0] PH_ENT2 = 4'd8; // read data valid
	localparam logic [3:0] PH_FIN  = 4'd9; // emit finish item

	logic [3:0] ph_q;
	logic [63:0] vacc_q;
	logic [3:0] vcnt_q;
	logic [31:0] plen_q, hleft_q, seen_q;
	logic [63:0] rid_q, val_q;
	logic [rcvp_pkg::CntW-1:0] ccnt_q, cur_q;
	logic [15:0] cleft_q;
	logic trunc_q;
	rcvp_pkg::col_info_t ci_q;
	rcvp_pkg::out_item_t ob_q;
	logic ob_v_q;

	logic [7:0] b;
	logic take, vdone;
	logic [63:0] vnext;
	logic [3:0] vcnt_n;
	logic [31:0] vsat;
	rcvp_pkg::col_info_t ci_n;
	logic ob_free;

	assign ob_free = !ob_v_q || res_ready;
	assign res_valid = ob_v_q;
	assign res_item = ob_q;
	assign b = in_item.cell_byte;
	assign ci_n = rcvp_pkg::classify(st_rdata);

	// input accepted only in byte-consuming phases, with the result slot free
	assign in_ready = ob_free && (ph_q == PH_IDLE || ph_q == PH_PAY || ph_q == PH_ROW ||
		ph_q == PH_HDR || ph_q == PH_SER || ph_q == PH_DATA || ph_q == PH_DONE);
	assign take = in_valid && in_ready;

	always_comb begin
		if (vcnt_q >= 4'd8) begin
			vnext = {vacc_q[55:0], b};
			vcnt_n = 4'd9;
			vdone = 1'b1;
		end else begin
			vnext = {vacc_q[56:0], b[6:0]};
			vcnt_n = vcnt_q + 4'd1;
			vdone = !b[7];
		end
		vsat = (vnext[63:32] != 32'd0) ? 32'hFFFFFFFF : vnext[31:0];
	end

	assign st_raddr = cur_q[rcvp_pkg::ColW-1:0];
	assign st_waddr = ccnt_q[rcvp_pkg::ColW-1:0];
	assign st_wdata = vsat;
	assign st_we = take && !in_item.cell_first && ph_q == PH_SER && seen_q < plen_q &&
		vdone && ccnt_q < rcvp_pkg::CntW'(rcvp_pkg::MaxColumns);

	function automatic rcvp_pkg::out_item_t mk(input logic [1:0] k,
		input logic [rcvp_pkg::CntW-1:0] c, input logic [2:0] cl, input logic [15:0] sz,
		input logic [63:0] rv, input logic [7:0] tb, input logic [63:0] ri,
		input logic tr, input logic l);
		rcvp_pkg::out_item_t o;
		o.item_kind = k;
		o.column_index = 5'(c);
		o.type_class = cl;
		o.data_size = sz;
		o.raw_value = rv;
		o.text_value_byte = tb;
		o.row_identifier = ri;
		o.truncated = tr;
		o.last = l;
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			vacc_q <= '0;
			vcnt_q <= '0;
			plen_q <= '0;
			hleft_q <= '0;
			seen_q <= '0;
			rid_q <= '0;
			val_q <= '0;
			ccnt_q <= '0;
			cur_q <= '0;
			cleft_q <= '0;
			trunc_q <= 1'b0;
			ob_v_q <= 1'b0;
			ci_q <= '0;
			ob_q <= '0;
		end else begin
			if (res_ready) ob_v_q <= 1'b0;
			if (take) begin : step
				logic [3:0] ph;
				logic [31:0] pl, sn, hl;
				logic tr;
				logic [63:0] va;
				logic [3:0] vc;
				logic [rcvp_pkg::CntW-1:0] cc;
				ph = ph_q; pl = plen_q; sn = seen_q; tr = trunc_q; va = vacc_q; vc = vcnt_q;
				cc = ccnt_q; hl = hleft_q;
				if (in_item.cell_first) begin
					ph = PH_PAY; pl = '0; sn = '0; tr = 1'b0; va = '0; vc = '0; cc = '0;
					hl = '0;
					rid_q <= '0;
					cur_q <= '0;
					cleft_q <= '0;
					val_q <= '0;
				end
				vacc_q <= va; vcnt_q <= vc; ph_q <= ph; plen_q <= pl; seen_q <= sn;
				trunc_q <= tr; ccnt_q <= cc; hleft_q <= hl;
				// varint computed from registered acc; on cell_first acc is cleared
				case (ph)
					PH_PAY: begin
						if (in_item.cell_first ? !b[7] : vdone) begin
							plen_q <= in_item.cell_first ? {24'd0, b} & 32'h7F : vsat;
							vacc_q <= '0; vcnt_q <= '0; ph_q <= PH_ROW;
						end else if (in_item.cell_first) begin
							vacc_q <= {57'd0, b[6:0]}; vcnt_q <= 4'd1;
						end else begin
							vacc_q <= vnext; vcnt_q <= vcnt_n;
						end
					end
					PH_ROW: begin
						if (vdone) begin
							rid_q <= vnext; vacc_q <= '0; vcnt_q <= '0; ph_q <= PH_HDR;
						end else begin
							vacc_q <= vnext; vcnt_q <= vcnt_n;
						end
					end
					PH_HDR, PH_SER, PH_DATA: begin
						if (sn >= pl) begin
							trunc_q <= 1'b1;
							ob_q <= mk(rcvp_pkg::KIND_FIN, '0, '0, '0, '0, '0, rid_q, 1'b1,
								1'b1);
							ob_v_q <= 1'b1;
							ph_q <= PH_DONE;
						end else begin
							seen_q <= sn + 32'd1;
							if (ph == PH_HDR) begin
								if (vdone) begin
									vacc_q <= '0; vcnt_q <= '0;
									if (vsat > {28'd0, vcnt_n}) begin
										hleft_q <= vsat - {28'd0, vcnt_n};
										ph_q <= PH_SER;
									end else begin
										cur_q <= '0; ph_q <= PH_ENT;
									end
								end else begin
									vacc_q <= vnext; vcnt_q <= vcnt_n;
								end
							end else if (ph == PH_SER) begin
								hleft_q <= hl - 32'd1;
								if (vdone) begin
									vacc_q <= '0; vcnt_q <= '0;
									if (cc < rcvp_pkg::CntW'(rcvp_pkg::MaxColumns))
										ccnt_q <= cc + 1'b1;
									else trunc_q <= 1'b1;
								end else begin
									vacc_q <= vnext; vcnt_q <= vcnt_n;
								end
								if (hl == 32'd1) begin
									vacc_q <= '0; vcnt_q <= '0;
									cur_q <= '0; ph_q <= PH_ENT;
								end
							end else begin : dat
								logic [15:0] cl;
								logic [63:0] v;
								cl = (cleft_q > 16'd0) ? cleft_q - 16'd1 : 16'd0;
								v = {val_q[55:0], b};
								cleft_q <= cl;
								if (ci_q.cls == rcvp_pkg::CLS_TEXT) begin
									ob_q <= mk(rcvp_pkg::KIND_TEXT, cur_q, rcvp_pkg::CLS_TEXT,
										ci_q.size, '0, b, '0, tr, 1'b0);
									ob_v_q <= 1'b1;
								end else if (ci_q.cls == rcvp_pkg::CLS_INT ||
									ci_q.cls == rcvp_pkg::CLS_FLT) begin
									val_q <= v;
								end
								if (cl == 16'd0) begin
									if (ci_q.cls == rcvp_pkg::CLS_INT ||
										ci_q.cls == rcvp_pkg::CLS_FLT) begin
										ob_q <= mk(rcvp_pkg::KIND_COL, cur_q, ci_q.cls,
											ci_q.size, v, '0, '0, tr, 1'b0);
										ob_v_q <= 1'b1;
									end
									cur_q <= cur_q + 1'b1;
									ph_q <= PH_ENT;
								end
							end
						end
					end
					default: ;
				endcase
			end else if (ob_free) begin
				case (ph_q)
					PH_ENT: begin
						if (cur_q >= ccnt_q) ph_q <= PH_FIN;
						else ph_q <= PH_ENT2;
					end
					PH_ENT2: begin
						ci_q <= ci_n;
						if (ci_n.size == 16'd0) begin
							ob_q <= mk(rcvp_pkg::KIND_COL, cur_q, ci_n.cls, '0, '0, '0, '0,
								trunc_q, 1'b0);
							ob_v_q <= 1'b1;
							cur_q <= cur_q + 1'b1;
							ph_q <= PH_ENT;
						end else begin
							cleft_q <= ci_n.size;
							val_q <= '0;
							if (ci_n.cls == rcvp_pkg::CLS_BLOB || ci_n.cls == rcvp_pkg::CLS_TEXT)
							begin
								ob_q <= mk(rcvp_pkg::KIND_COL, cur_q, ci_n.cls, ci_n.size, '0,
									'0, '0, trunc_q, 1'b0);
								ob_v_q <= 1'b1;
							end
							ph_q <= PH_DATA;
						end
					end
					PH_FIN: begin
						ob_q <= mk(rcvp_pkg::KIND_FIN, '0, '0, '0, '0, '0, rid_q, trunc_q, 1'b1);
						ob_v_q <= 1'b1;
						ph_q <= PH_DONE;
					end
					default: ;
				endcase
			end
		end
	end
endmodule

// ----- hw/rtl/record_cell_varint_parser.sv -----
// Latency: a byte's result item is registered and shown the cycle after the byte is taken.
// Throughput: one byte per cycle unless the result slot is full or the walk runs; on
// reaching each column the walk passes a serial type memory read state, then a classify
// state, and the finish item its own state; blob bytes give no item.
// Reset: arst_n clears the sequencer to idle; bytes before a first-byte mark are dropped.
module record_cell_varint_parser (
	input logic clk,
	input logic arst_n,
	rcvp_in_if.sink in_ch,
	rcvp_out_if.source out_ch
);
	rcvp_pkg::in_item_t in_item;
	rcvp_pkg::out_item_t res;
	logic we;
	logic [rcvp_pkg::ColW-1:0] wa, ra;
	logic [31:0] wd, rd;

	assign in_item.cell_byte = in_ch.cell_byte;
	assign in_item.cell_first = in_ch.cell_first;

	rcvp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_item),
		.res_valid(out_ch.valid), .res_ready(out_ch.ready), .res_item(res),
		.st_we(we), .st_waddr(wa), .st_wdata(wd), .st_raddr(ra), .st_rdata(rd)
	);

	rcvp_store u_store (
		.clk(clk), .we(we), .waddr(wa), .wdata(wd), .raddr(ra), .rdata(rd)
	);

	assign out_ch.item_kind = res.item_kind;
	assign out_ch.column_index = res.column_index;
	assign out_ch.type_class = res.type_class;
	assign out_ch.data_size = res.data_size;
	assign out_ch.raw_value = res.raw_value;
	assign out_ch.text_value_byte = res.text_value_byte;
	assign out_ch.row_identifier = res.row_identifier;
	assign out_ch.truncated = res.truncated;
	assign out_ch.last = res.last;
endmodule

// ----- hw/rtl/rcvp_checker.sv -----
// Port-level checker for the record parser, bound to the top level
`include "assert_macros.svh"
module rcvp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] item_kind,
	input logic [2:0] type_class,
	input logic last,
	input logic [63:0] raw_value
);
	`CHK_IMPL(a_last_kind, clk, arst_n, out_valid, (last == (item_kind == rcvp_pkg::KIND_FIN)), "last only on finish item")
	`CHK_IMPL(a_text_cls, clk, arst_n, out_valid && item_kind == rcvp_pkg::KIND_TEXT, type_class == rcvp_pkg::CLS_TEXT, "text item class")
	`CHK_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(item_kind), "stalled item changed")
	`CHK_IMPL(a_raw_zero, clk, arst_n, out_valid && type_class != rcvp_pkg::CLS_INT && type_class != rcvp_pkg::CLS_FLT, raw_value == 64'd0, "raw value on non-numeric item")
	`CHK_IMPL(a_in_block, clk, arst_n, in_valid && out_valid && !out_ready, !in_ready, "input taken while result stalled")
endmodule

bind record_cell_varint_parser rcvp_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.item_kind(out_ch.item_kind), .type_class(out_ch.type_class),
	.last(out_ch.last), .raw_value(out_ch.raw_value)
);
